[rtl/ssbm_pkg.sv]
// ----------------------------------------------------------------------------
// ssbm_pkg
// Shared types for the soft-switch bank mapper: access regions, the switch
// flag set and the decoded result of one access.
// ----------------------------------------------------------------------------
package ssbm_pkg;

  // access kind
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // region codes of a decoded access
  typedef enum logic [2:0] {
    REG_RAM     = 3'd0,
    REG_SWITCH  = 3'd1,
    REG_INTROM  = 3'd2,
    REG_SLOTROM = 3'd3,
    REG_SLOTC8  = 3'd4,
    REG_LCAREA  = 3'd5,
    REG_EXTIO   = 3'd6
  } region_t;

  // soft-switch flags
  typedef struct packed {
    logic aux_read;
    logic aux_write;
    logic aux_zero_page;
    logic store_80;
    logic second_page;
    logic high_res;
    logic graphics_mode;
    logic mixed_mode;
    logic col_80;
    logic alt_charset;
    logic double_hires;
    logic iou_disable;
    logic slot_rom_on;
    logic slot3_rom_on;
    logic internal_c8_rom;
  } flags_t;

  localparam flags_t FLAGS_RESET = '{
    slot_rom_on: 1'b1,
    default:     1'b0
  };

  // decoded result of one access
  typedef struct packed {
    region_t    region;
    logic       aux_bank;
    logic [2:0] slot_number;
    logic [7:0] read_data;
    logic       speaker_toggle;
    logic       video_changed;
    logic [7:0] video_flags;
  } result_t;

endpackage

[rtl/ssbm_req_if.sv]
// ----------------------------------------------------------------------------
// ssbm_req_if
// Bus access channel: one item is a read or write at a 16-bit address.
// ----------------------------------------------------------------------------
interface ssbm_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

[rtl/ssbm_rsp_if.sv]
// ----------------------------------------------------------------------------
// ssbm_rsp_if
// Result channel: one item is the classification of one bus access.
// ----------------------------------------------------------------------------
interface ssbm_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] region;
  logic       aux_bank;
  logic [2:0] slot_number;
  logic [7:0] read_data;
  logic       speaker_toggle;
  logic       video_changed;
  logic [7:0] video_flags;

  modport source (output valid, output region, output aux_bank, output slot_number,
                  output read_data, output speaker_toggle, output video_changed,
                  output video_flags, input ready);
  modport sink   (input valid, input region, input aux_bank, input slot_number,
                  input read_data, input speaker_toggle, input video_changed,
                  input video_flags, output ready);
endinterface

[rtl/ssbm_decode.sv]
// ----------------------------------------------------------------------------
// ssbm_decode
// Combinational decode of one access: region, bank, status byte, and the
// soft-switch flags as they stand after the access.
// ----------------------------------------------------------------------------
module ssbm_decode (
  input  logic             opcode,
  input  logic [15:0]      address,
  input  ssbm_pkg::flags_t flags,
  output ssbm_pkg::flags_t flags_next,
  output ssbm_pkg::result_t result
);
  import ssbm_pkg::*;

  // page boundaries
  localparam logic [7:0] PG_STACK_END = 8'h02;
  localparam logic [7:0] PG_TEXT_LO   = 8'h04;
  localparam logic [7:0] PG_TEXT_HI   = 8'h08;
  localparam logic [7:0] PG_HIRES_LO  = 8'h20;
  localparam logic [7:0] PG_HIRES_HI  = 8'h40;
  localparam logic [7:0] PG_IO        = 8'hC0;
  localparam logic [7:0] PG_SLOT3     = 8'hC3;
  localparam logic [7:0] PG_C8        = 8'hC8;
  localparam logic [7:0] PG_LC        = 8'hD0;
  localparam logic [7:0] LO_EXTIO     = 8'h90;

  // write-only switches
  localparam logic [7:0] SW_80STORE_OFF = 8'h00;
  localparam logic [7:0] SW_80STORE_ON  = 8'h01;
  localparam logic [7:0] SW_RAMRD_OFF   = 8'h02;
  localparam logic [7:0] SW_RAMRD_ON    = 8'h03;
  localparam logic [7:0] SW_RAMWRT_OFF  = 8'h04;
  localparam logic [7:0] SW_RAMWRT_ON   = 8'h05;
  localparam logic [7:0] SW_SLOTROM_ON  = 8'h06;
  localparam logic [7:0] SW_SLOTROM_OFF = 8'h07;
  localparam logic [7:0] SW_ALTZP_OFF   = 8'h08;
  localparam logic [7:0] SW_ALTZP_ON    = 8'h09;
  localparam logic [7:0] SW_SLOT3_OFF   = 8'h0A;
  localparam logic [7:0] SW_SLOT3_ON    = 8'h0B;
  localparam logic [7:0] SW_80COL_OFF   = 8'h0C;
  localparam logic [7:0] SW_80COL_ON    = 8'h0D;
  localparam logic [7:0] SW_ALTCH_OFF   = 8'h0E;
  localparam logic [7:0] SW_ALTCH_ON    = 8'h0F;
  localparam logic [7:0] SW_IOU_DIS     = 8'h7E;
  localparam logic [7:0] SW_IOU_EN      = 8'h7F;

  // status reads
  localparam logic [7:0] ST_RAMRD   = 8'h13;
  localparam logic [7:0] ST_RAMWRT  = 8'h14;
  localparam logic [7:0] ST_INTCX   = 8'h15;
  localparam logic [7:0] ST_ALTZP   = 8'h16;
  localparam logic [7:0] ST_SLOT3   = 8'h17;
  localparam logic [7:0] ST_80STORE = 8'h18;
  localparam logic [7:0] ST_TEXT    = 8'h1A;
  localparam logic [7:0] ST_MIXED   = 8'h1B;
  localparam logic [7:0] ST_PAGE2   = 8'h1C;
  localparam logic [7:0] ST_HIRES   = 8'h1D;
  localparam logic [7:0] ST_ALTCH   = 8'h1E;
  localparam logic [7:0] ST_80COL   = 8'h1F;
  localparam logic [7:0] ST_IOUDIS  = 8'h7E;
  localparam logic [7:0] ST_DHIRES  = 8'h7F;
  localparam logic [7:0] LO_SPK_LO  = 8'h30;
  localparam logic [7:0] LO_SPK_HI  = 8'h3F;

  // switches shared by reads and writes
  localparam logic [7:0] SW_GR_ON     = 8'h50;
  localparam logic [7:0] SW_GR_OFF    = 8'h51;
  localparam logic [7:0] SW_MIXED_OFF = 8'h52;
  localparam logic [7:0] SW_MIXED_ON  = 8'h53;
  localparam logic [7:0] SW_PAGE1     = 8'h54;
  localparam logic [7:0] SW_PAGE2     = 8'h55;
  localparam logic [7:0] SW_LORES     = 8'h56;
  localparam logic [7:0] SW_HIRES     = 8'h57;
  localparam logic [7:0] SW_DHIRES_ON = 8'h5E;
  localparam logic [7:0] SW_DHIRES_OFF = 8'h5F;

  logic [7:0] page;
  logic [7:0] lo;
  logic       rw_aux;
  logic       status;
  logic       common_vid;
  flags_t     nf;
  flags_t     cf;

  assign page   = address[15:8];
  assign lo     = address[7:0];
  assign rw_aux = (opcode == OP_WRITE) ? flags.aux_write : flags.aux_read;

  // shared video switches, applied to the current flags
  always_comb begin
    cf         = flags;
    common_vid = 1'b0;
    case (lo)
      SW_GR_ON:     begin cf.graphics_mode = 1'b1; common_vid = 1'b1; end
      SW_GR_OFF:    begin cf.graphics_mode = 1'b0; common_vid = 1'b1; end
      SW_MIXED_OFF: begin cf.mixed_mode = 1'b0; common_vid = 1'b1; end
      SW_MIXED_ON:  begin cf.mixed_mode = 1'b1; common_vid = 1'b1; end
      SW_PAGE1: begin
        cf.second_page = 1'b0;
        common_vid     = flags.second_page & ~flags.store_80;
      end
      SW_PAGE2: begin
        cf.second_page = 1'b1;
        common_vid     = ~flags.second_page & ~flags.store_80;
      end
      SW_LORES: begin
        cf.high_res = 1'b0;
        common_vid  = flags.high_res;
      end
      SW_HIRES: begin
        cf.high_res = 1'b1;
        common_vid  = ~flags.high_res;
      end
      SW_DHIRES_ON: begin cf.double_hires = 1'b1; common_vid = 1'b1; end
      SW_DHIRES_OFF: begin
        if (flags.iou_disable) begin
          cf.double_hires = 1'b0;
        end
        common_vid = flags.iou_disable;
      end
      default: ;
    endcase
  end

  // region, bank and switch effects
  always_comb begin
    nf                    = flags;
    result.region         = REG_RAM;
    result.aux_bank       = 1'b0;
    result.slot_number    = 3'd0;
    result.read_data      = 8'h00;
    result.speaker_toggle = 1'b0;
    result.video_changed  = 1'b0;
    status                = 1'b0;

    if (page < PG_STACK_END) begin
      result.aux_bank = flags.aux_zero_page;
    end else if (page >= PG_TEXT_LO && page < PG_TEXT_HI) begin
      result.aux_bank = flags.store_80 ? flags.second_page : rw_aux;
    end else if (page >= PG_HIRES_LO && page < PG_HIRES_HI) begin
      result.aux_bank = (flags.store_80 & flags.high_res) ? flags.second_page : rw_aux;
    end else if (page < PG_IO) begin
      result.aux_bank = rw_aux;
    end else if (page == PG_IO) begin
      if (lo >= LO_EXTIO) begin
        result.region      = REG_EXTIO;
        result.slot_number = lo[6:4];
      end else if (opcode == OP_WRITE) begin
        result.region = REG_SWITCH;
        case (lo)
          SW_80STORE_OFF: nf.store_80 = 1'b0;
          SW_80STORE_ON:  nf.store_80 = 1'b1;
          SW_RAMRD_OFF:   nf.aux_read = 1'b0;
          SW_RAMRD_ON:    nf.aux_read = 1'b1;
          SW_RAMWRT_OFF:  nf.aux_write = 1'b0;
          SW_RAMWRT_ON:   nf.aux_write = 1'b1;
          SW_SLOTROM_ON:  nf.slot_rom_on = 1'b1;
          SW_SLOTROM_OFF: nf.slot_rom_on = 1'b0;
          SW_ALTZP_OFF:   nf.aux_zero_page = 1'b0;
          SW_ALTZP_ON:    nf.aux_zero_page = 1'b1;
          SW_SLOT3_OFF:   nf.slot3_rom_on = 1'b0;
          SW_SLOT3_ON:    nf.slot3_rom_on = 1'b1;
          SW_80COL_OFF: begin nf.col_80 = 1'b0; result.video_changed = 1'b1; end
          SW_80COL_ON:  begin nf.col_80 = 1'b1; result.video_changed = 1'b1; end
          SW_ALTCH_OFF:   nf.alt_charset = 1'b0;
          SW_ALTCH_ON:    nf.alt_charset = 1'b1;
          SW_IOU_DIS:     nf.iou_disable = 1'b1;
          SW_IOU_EN:      nf.iou_disable = 1'b0;
          default: begin
            nf                   = cf;
            result.video_changed = common_vid;
          end
        endcase
      end else begin
        result.region = REG_SWITCH;
        case (lo)
          ST_RAMRD:   status = flags.aux_read;
          ST_RAMWRT:  status = flags.aux_write;
          ST_INTCX:   status = ~flags.slot_rom_on;
          ST_ALTZP:   status = flags.aux_zero_page;
          ST_SLOT3:   status = flags.slot3_rom_on;
          ST_80STORE: status = flags.store_80;
          ST_TEXT:    status = ~flags.graphics_mode;
          ST_MIXED:   status = flags.mixed_mode;
          ST_PAGE2:   status = flags.second_page;
          ST_HIRES:   status = flags.high_res;
          ST_ALTCH:   status = flags.alt_charset;
          ST_80COL:   status = flags.col_80;
          ST_IOUDIS:  status = ~flags.iou_disable;
          ST_DHIRES:  status = flags.double_hires;
          default: begin
            if (lo >= LO_SPK_LO && lo <= LO_SPK_HI) begin
              result.speaker_toggle = 1'b1;
            end else begin
              nf                   = cf;
              result.video_changed = common_vid;
            end
          end
        endcase
        result.read_data = {status, 7'd0};
      end
    end else if (page < PG_LC) begin
      // Cx ROM space
      if (!flags.slot_rom_on) begin
        result.region = REG_INTROM;
      end else if (page >= PG_C8) begin
        result.region = flags.internal_c8_rom ? REG_INTROM : REG_SLOTC8;
      end else if (page == PG_SLOT3 && !flags.slot3_rom_on) begin
        result.region      = REG_INTROM;
        nf.internal_c8_rom = 1'b1;
      end else begin
        result.region      = REG_SLOTROM;
        result.slot_number = page[2:0];
      end
    end else begin
      result.region   = REG_LCAREA;
      result.aux_bank = flags.aux_zero_page;
    end

    result.video_flags = {nf.store_80, nf.double_hires, nf.alt_charset, nf.col_80,
                          nf.high_res, nf.second_page, nf.mixed_mode, nf.graphics_mode};
  end

  assign flags_next = nf;

endmodule

[rtl/soft_switch_bank_mapper.sv]
// ----------------------------------------------------------------------------
// soft_switch_bank_mapper
// Soft-switch bank mapper: classifies each bus access, picks the RAM bank and
// keeps the soft-switch flags.
//
// Usage:
//   req carries one access per item (opcode 0 read / 1 write, 16-bit address).
//   rsp returns one item per access, in order: region, bank, slot number,
//   status byte, speaker toggle, video-change flag and the video flags after
//   the access.
//   An accepted access is loaded into the input register; its decode is then
//   loaded into the result register, from which rsp takes it.
//   Throughput: one access per cycle; the input register feeds the result
//   register each cycle the result is empty or being taken.
//   Stall: while rsp.ready is low the result holds; one more access can sit
//   in the input register, after which req.ready drops.
//   Reset (rst, synchronous): empties both registers and returns the flags
//   to their power-on values, slot ROM mapped and all else off.
// ----------------------------------------------------------------------------
module soft_switch_bank_mapper (
  input logic        clk,
  input logic        rst,
  ssbm_req_if.sink   req,
  ssbm_rsp_if.source rsp
);
  import ssbm_pkg::*;

  logic        in_valid;
  logic        in_opcode;
  logic [15:0] in_address;
  logic        out_valid;
  result_t     out_result;
  flags_t      flags;
  flags_t      flags_next;
  result_t     result;
  logic        advance;

  // move the input register into the result register
  assign advance   = in_valid & (~out_valid | rsp.ready);
  assign req.ready = ~in_valid | advance;

  ssbm_decode u_decode (
    .opcode     (in_opcode),
    .address    (in_address),
    .flags      (flags),
    .flags_next (flags_next),
    .result     (result)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      in_opcode  <= req.opcode;
      in_address <= req.address;
    end
  end

  // flag state, updated as each item is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= FLAGS_RESET;
    end else if (advance) begin
      flags <= flags_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= result;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.region         = out_result.region;
  assign rsp.aux_bank       = out_result.aux_bank;
  assign rsp.slot_number    = out_result.slot_number;
  assign rsp.read_data      = out_result.read_data;
  assign rsp.speaker_toggle = out_result.speaker_toggle;
  assign rsp.video_changed  = out_result.video_changed;
  assign rsp.video_flags    = out_result.video_flags;

endmodule
